// ===== rtl/mapt_pkg.sv =====
`timescale 1ns / 1ps
package mapt_pkg;

  localparam int FRAC_W    = 30;
  localparam int PI_W      = 48;
  localparam int MU_W      = 32;
  localparam int ORD_W     = 7;
  localparam int ACC_W     = 64;
  localparam int OPND_W    = 33;
  localparam int NUM_W     = 58;
  localparam int QUO_W     = 56;
  localparam int DEN_W     = 6;
  localparam int SPLIT_W   = 25;

  localparam logic signed [PI_W-1:0]  ONE_PI = 48'sd1 <<< FRAC_W;
  localparam logic signed [ACC_W-1:0] PI_MAX = (64'sd1 <<< (PI_W - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] PI_MIN = -(64'sd1 <<< (PI_W - 1));

  typedef struct packed {
    logic signed [MU_W-1:0] cos_angle;
    logic [ORD_W-1:0]       order_count;
  } in_word_t;

  typedef struct packed {
    logic [ORD_W-1:0]       order_index;
    logic signed [PI_W-1:0] pi_value;
    logic signed [PI_W-1:0] tau_value;
    logic                   last_order;
  } out_word_t;

  typedef enum logic [1:0] {
    ACC_CLEAR = 2'd0,
    ACC_HOLD  = 2'd1,
    ACC_SHR   = 2'd2,
    ACC_SHL   = 2'd3
  } acc_mode_t;

  typedef struct packed {
    logic                     valid;
    acc_mode_t                mode;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
  } mac_op_t;

  function automatic logic signed [PI_W-1:0] sat_pi(input logic signed [ACC_W-1:0] x);
    logic signed [PI_W-1:0] res;
    if (x > PI_MAX) begin
      res = PI_MAX[PI_W-1:0];
    end else if (x < PI_MIN) begin
      res = PI_MIN[PI_W-1:0];
    end else begin
      res = x[PI_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/mie_angular_pi_tau_generator.sv =====
`timescale 1ns / 1ps
// the input word moves the sequencer to ST_OUT1, which registers order 1, then
// ST_OUT2 registers order 2, both waiting while the output stalls; each further
// order runs two fx products and two scalings on the shared multiply-accumulate
// unit plus a divide at 4 quotient bits/cycle; one input word is taken at a time
// synchronous active-low reset clears the sequencer and output valid
module mie_angular_pi_tau_generator #(
  parameter int ORDER_LIMIT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mapt_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mapt_pkg::out_word_t  out_word
);
  import mapt_pkg::*;

  localparam logic [ORD_W-1:0] MaxOrd = ORD_W'(ORDER_LIMIT);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_OUT1  = 7'b0000010,
    ST_OUT2  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [2:0]              step_r, step_nxt;
  logic                    tau_ph_r, tau_ph_nxt;
  logic signed [MU_W-1:0]  mu_r, mu_nxt;
  logic [ORD_W-1:0]        cnt_r, cnt_nxt;
  logic [ORD_W-1:0]        k_r, k_nxt;
  logic signed [PI_W-1:0]  p_r, p_nxt;
  logic signed [PI_W-1:0]  pp_r, pp_nxt;
  logic signed [PI_W-1:0]  pc_r, pc_nxt;
  logic signed [PI_W-1:0]  tau_r, tau_nxt;
  logic signed [49:0]      x_r, x_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r, out_word_nxt;

  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] acc;
  logic                    div_start;
  logic                    div_done;
  logic signed [PI_W-1:0]  div_quo;

  logic                    out_free;
  logic [ORD_W-1:0]        n_clamp;
  logic signed [PI_W-1:0]  mop, qop;
  logic [7:0]              c1, c2;
  logic signed [OPND_W-1:0] mu33, c1_33, nc2_33;
  logic signed [PI_W-1:0]  mu48, pi2, sq48, t48, tau2;

  mapt_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .acc   (acc)
  );

  mapt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc[NUM_W-1:0]),
    .den   (DEN_W'(k_r - 1'b1)),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    if (in_word.order_count < 7'd2) begin
      n_clamp = 7'd2;
    end else if (in_word.order_count > MaxOrd) begin
      n_clamp = MaxOrd;
    end else begin
      n_clamp = in_word.order_count;
    end
  end

  assign mop    = tau_ph_r ? pc_r : p_r;
  assign qop    = tau_ph_r ? p_r : pp_r;
  assign c1     = tau_ph_r ? {1'b0, k_r} : ({1'b0, k_r} << 1) - 8'd1;
  assign c2     = tau_ph_r ? {1'b0, k_r} + 8'd1 : {1'b0, k_r};
  assign mu33   = {mu_r[MU_W-1], mu_r};
  assign c1_33  = $signed({25'b0, c1});
  assign nc2_33 = -$signed({25'b0, c2});

  // second-order seeds
  assign mu48 = {{(PI_W-MU_W){mu_r[MU_W-1]}}, mu_r};
  assign pi2  = mu48 + (mu48 <<< 1);
  assign sq48 = {{14{acc[ACC_W-1]}}, acc[ACC_W-1:FRAC_W]};
  assign t48  = (sq48 <<< 1) - ONE_PI;
  assign tau2 = t48 + (t48 <<< 1);

  always_comb begin
    mac_op = '{valid: 1'b0, mode: ACC_HOLD, a: '0, b: '0};
    if (state_r == ST_IDLE) begin
      mac_op.valid = in_valid;
      mac_op.mode  = ACC_CLEAR;
      mac_op.a     = {in_word.cos_angle[MU_W-1], in_word.cos_angle};
      mac_op.b     = {in_word.cos_angle[MU_W-1], in_word.cos_angle};
    end else if (state_r == ST_MUL) begin
      case (step_r)
        3'd0: begin
          mac_op = '{valid: 1'b1, mode: ACC_CLEAR, a: mu33,
                     b: $signed({3'b0, mop[FRAC_W-1:0]})};
        end
        3'd1: begin
          mac_op = '{valid: 1'b1, mode: ACC_SHR, a: mu33,
                     b: {{15{mop[PI_W-1]}}, mop[PI_W-1:FRAC_W]}};
        end
        default: mac_op.valid = 1'b0;
      endcase
    end else if (state_r == ST_SCALE) begin
      case (step_r)
        3'd0: begin
          mac_op = '{valid: 1'b1, mode: ACC_CLEAR, a: c1_33,
                     b: {{8{x_r[49]}}, x_r[49:SPLIT_W]}};
        end
        3'd1: begin
          mac_op = '{valid: 1'b1, mode: ACC_HOLD, a: nc2_33,
                     b: {{10{qop[PI_W-1]}}, qop[PI_W-1:SPLIT_W]}};
        end
        3'd2: begin
          mac_op = '{valid: 1'b1, mode: ACC_SHL, a: c1_33,
                     b: $signed({8'b0, x_r[SPLIT_W-1:0]})};
        end
        3'd3: begin
          mac_op = '{valid: 1'b1, mode: ACC_HOLD, a: nc2_33,
                     b: $signed({8'b0, qop[SPLIT_W-1:0]})};
        end
        default: mac_op.valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    tau_ph_nxt    = tau_ph_r;
    mu_nxt        = mu_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    pp_nxt        = pp_r;
    pc_nxt        = pc_r;
    tau_nxt       = tau_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mu_nxt    = in_word.cos_angle;
          cnt_nxt   = n_clamp;
          state_nxt = ST_OUT1;
        end
      end
      ST_OUT1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{order_index: 7'd1, pi_value: ONE_PI, tau_value: mu48,
                            last_order: 1'b0};
          state_nxt     = ST_OUT2;
        end
      end
      ST_OUT2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{order_index: 7'd2, pi_value: pi2, tau_value: tau2,
                            last_order: (cnt_r == 7'd2)};
          pp_nxt        = ONE_PI;
          p_nxt         = pi2;
          k_nxt         = 7'd3;
          tau_ph_nxt    = 1'b0;
          step_nxt      = '0;
          state_nxt     = (cnt_r == 7'd2) ? ST_IDLE : ST_MUL;
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd3) begin
          x_nxt     = acc[49:0];
          step_nxt  = '0;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd5) begin
          step_nxt = '0;
          if (tau_ph_r) begin
            tau_nxt   = sat_pi(acc);
            state_nxt = ST_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          pc_nxt     = div_quo;
          tau_ph_nxt = 1'b1;
          step_nxt   = '0;
          state_nxt  = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{order_index: k_r, pi_value: pc_r, tau_value: tau_r,
                            last_order: (k_r == cnt_r)};
          pp_nxt        = p_r;
          p_nxt         = pc_r;
          tau_ph_nxt    = 1'b0;
          step_nxt      = '0;
          if (k_r == cnt_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 7'd1;
            state_nxt = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      tau_ph_r    <= 1'b0;
      cnt_r       <= 7'd2;
      k_r         <= 7'd3;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      tau_ph_r    <= tau_ph_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mu_r       <= mu_nxt;
    p_r        <= p_nxt;
    pp_r       <= pp_nxt;
    pc_r       <= pc_nxt;
    tau_r      <= tau_nxt;
    x_r        <= x_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divide finished outside divide wait");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> cnt_r >= 7'd2 && cnt_r <= MaxOrd)
    else $error("order count out of range during a run");

  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_SCALE || state_r == ST_DIV || state_r == ST_OUT)
      |-> k_r >= 7'd3 && k_r <= cnt_r)
    else $error("recurrence order out of range");

  a_div_start_pi: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !tau_ph_r && k_r >= 7'd3)
    else $error("divide started in tau phase");

endmodule

// ===== rtl/mapt_mac.sv =====
`timescale 1ns / 1ps
module mapt_mac (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mapt_pkg::mac_op_t               op,
  output logic signed [mapt_pkg::ACC_W-1:0] acc
);
  import mapt_pkg::*;

  logic signed [2*OPND_W-1:0] prod;
  logic signed [ACC_W-1:0]    prod_r, prod_nxt;
  acc_mode_t                  mode_r, mode_nxt;
  logic                       vld_r, vld_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W-1:0]    base;

  assign prod = op.a * op.b;

  always_comb begin
    prod_nxt = prod[ACC_W-1:0];
    mode_nxt = op.mode;
    vld_nxt  = op.valid;
    case (mode_r)
      ACC_CLEAR: base = '0;
      ACC_HOLD:  base = acc_r;
      ACC_SHR:   base = acc_r >>> FRAC_W;
      ACC_SHL:   base = acc_r <<< SPLIT_W;
      default:   base = '0;
    endcase
    acc_nxt = vld_r ? base + prod_r : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    mode_r <= mode_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== rtl/mapt_div.sv =====
`timescale 1ns / 1ps
module mapt_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [mapt_pkg::NUM_W-1:0] num,
  input  logic [mapt_pkg::DEN_W-1:0]        den,
  output logic                              done,
  output logic signed [mapt_pkg::PI_W-1:0]  quo
);
  import mapt_pkg::*;

  localparam int STEP_BITS = 4;
  localparam int STEPS     = QUO_W / STEP_BITS;
  localparam int CNT_W     = $clog2(STEPS);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [QUO_W-1:0]        mag_r, mag_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic                    neg_r, neg_nxt;
  logic [DEN_W-1:0]        r;
  logic [DEN_W:0]          t;
  logic [QUO_W-1:0]        m;
  logic signed [NUM_W-1:0] num_abs;
  logic signed [ACC_W-1:0] q_signed;

  always_comb begin
    r = rem_r;
    m = mag_r;
    for (int j = 0; j < STEP_BITS; j++) begin
      t = {r, m[QUO_W-1]};
      m = {m[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        r    = DEN_W'(t - {1'b0, den_r});
        m[0] = 1'b1;
      end else begin
        r = t[DEN_W-1:0];
      end
    end
  end

  assign num_abs = num[NUM_W-1] ? -num : num;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mag_nxt  = num_abs[QUO_W-1:0];
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[NUM_W-1];
    end else if (busy_r) begin
      mag_nxt = m;
      rem_nxt = r;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? -$signed({{(ACC_W-QUO_W){1'b0}}, mag_r})
                          :  $signed({{(ACC_W-QUO_W){1'b0}}, mag_r});
  assign quo  = sat_pi(q_signed);
  assign done = done_r;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import mapt_pkg::*;

  localparam int ORDER_LIMIT   = 64;
  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_WORDS  = 92;

  class pi_tau_scoreboard;
    out_word_t expected_q[$];
    longint    pi_last, pi_older, cos_held;
    int        order_total;
    int        mismatches, results_checked, clamped_words, wide_words, words_seen;

    task report(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // floor(mu * p / 2^30) split so the product stays inside 64 bits
    function longint mul_q30(longint mu, longint p);
      longint hi, lo;
      hi = p >>> FRAC_W;
      lo = p - (hi <<< FRAC_W);
      return mu * hi + ((mu * lo) >>> FRAC_W);
    endfunction

    function longint clamp48(longint x);
      if (x > PI_MAX) return PI_MAX;
      if (x < PI_MIN) return PI_MIN;
      return x;
    endfunction

    function void push_result(int idx, longint pv, longint tv, bit last);
      out_word_t r;
      r.order_index = ORD_W'(idx);
      r.pi_value    = pv[PI_W-1:0];
      r.tau_value   = tv[PI_W-1:0];
      r.last_order  = last;
      expected_q = {expected_q, r};
    endfunction

    function void note_input(in_word_t w);
      longint mu, older, prev, next, tau, i;
      int count;
      mu = longint'($signed(w.cos_angle));
      count = int'(w.order_count);
      words_seen++;
      if (count < 2 || count > ORDER_LIMIT) clamped_words++;
      if (mu > longint'(ONE_PI) || mu < -longint'(ONE_PI)) wide_words++;
      if (count < 2) count = 2;
      if (count > ORDER_LIMIT) count = ORDER_LIMIT;
      older = longint'(ONE_PI);
      prev  = 3 * mu;
      push_result(1, older, mu, 1'b0);
      push_result(2, prev, 3 * (2 * ((mu * mu) >>> FRAC_W) - longint'(ONE_PI)), count == 2);
      for (int k = 3; k <= count; k++) begin
        i     = k - 1;
        next  = clamp48(((2 * i + 1) * mul_q30(mu, prev) - (i + 1) * older) / i);
        tau   = clamp48((i + 1) * mul_q30(mu, next) - (i + 2) * prev);
        older = prev;
        prev  = next;
        push_result(k, next, tau, k == count);
      end
      pi_last     = prev;
      pi_older    = older;
      order_total = count;
      cos_held    = mu;
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, order %0d", got.order_index));
        return;
      end
      want = expected_q.pop_front();
      if (got.order_index !== want.order_index)
        report($sformatf("order_index %0d, want %0d", got.order_index, want.order_index));
      if (got.pi_value !== want.pi_value)
        report($sformatf("order %0d pi_value %0d, want %0d", want.order_index,
                         got.pi_value, want.pi_value));
      if (got.tau_value !== want.tau_value)
        report($sformatf("order %0d tau_value %0d, want %0d", want.order_index,
                         got.tau_value, want.tau_value));
      if (got.last_order !== want.last_order)
        report($sformatf("order %0d last_order %0b, want %0b", want.order_index,
                         got.last_order, want.last_order));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  bit               idle_enable = 1'b0;
  int               stuck_cycles = 0;
  pi_tau_scoreboard sb;

  mie_angular_pi_tau_generator #(.ORDER_LIMIT(ORDER_LIMIT)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_word);
      if (in_valid && !in_stall) sb.note_input(in_word);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // result side stalls in short bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic in_word_t cos_word(longint mu, int count);
    in_word_t w;
    w.cos_angle   = mu[MU_W-1:0];
    w.order_count = ORD_W'(count);
    return w;
  endfunction

  function automatic in_word_t random_word();
    longint mu;
    int     count;
    if ($urandom_range(0, 4) == 0) begin
      mu = longint'($signed($urandom()));
    end else begin
      mu = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
    end
    if ($urandom_range(0, 9) == 0) begin
      count = $urandom_range(127, 0);
    end else begin
      count = $urandom_range(8, 0);
    end
    return cos_word(mu, count);
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = (idle_enable && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    in_word_t directed[$];
    sb = new();
    directed = {directed, cos_word(0, 0)};
    directed = {directed, cos_word(0, 1)};
    directed = {directed, cos_word(64'sd1073741824, 2)};
    directed = {directed, cos_word(-64'sd1073741824, 2)};
    directed = {directed, cos_word(64'sd1073741824, 64)};
    directed = {directed, cos_word(-64'sd1073741824, 64)};
    directed = {directed, cos_word(64'sd536870912, 3)};
    directed = {directed, cos_word(-64'sd536870912, 7)};
    directed = {directed, cos_word(1, 4)};
    directed = {directed, cos_word(-1, 4)};
    directed = {directed, cos_word(64'sd2147483647, 64)};
    directed = {directed, cos_word(-64'sd2147483648, 127)};
    directed = {directed, cos_word(64'sd1073741825, 20)};
    directed = {directed, cos_word(-64'sd1073741825, 65)};
    directed = {directed, cos_word(64'sd858993459, 100)};
    directed = {directed, cos_word(0, 64)};
    directed = {directed, cos_word(-64'sd322122547, 12)};
    directed = {directed, cos_word(64'sd1073741824, 63)};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    idle_enable = 1'b1;
    foreach (directed[k]) send_word(directed[k]);
    wait_for_drain();

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      idle_enable = (k < 40) || (k >= 55 && k < 85);
      send_word(random_word());
      if (k == 70) wait_for_drain();
    end
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d cosine words, %0d beyond unit magnitude, %0d with clamped order",
             sb.words_seen, sb.wide_words, sb.clamped_words);
    $display("checked %0d pi/tau results, %0d mismatches", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mapt_pkg.sv
rtl/mapt_mac.sv
rtl/mapt_div.sv
rtl/mie_angular_pi_tau_generator.sv
tb/sv/testbench.sv
